// ----- hdl/ubxp_pkg.sv -----
package ubxp_pkg;

  localparam logic [7:0]  SYNC_FIRST   = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND  = 8'h62;
  localparam logic [7:0]  CLASS_NAV    = 8'h01;
  localparam logic [7:0]  ID_PVT       = 8'h07;
  localparam logic [15:0] PVT_MIN_LEN  = 16'd92;
  localparam logic [7:0]  FIX_TYPE_MIN = 8'd2;
  localparam logic [15:0] FIX_TYPE_OFS = 16'd20;
  localparam logic [15:0] FIX_FLAG_OFS = 16'd21;
  localparam logic [15:0] MAX_LEN_RST  = 16'd512;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [8:0] {
    PH_HUNT1   = 9'b000000001,
    PH_HUNT2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LENLO   = 9'b000010000,
    PH_LENHI   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CKA     = 9'b010000000,
    PH_CKB     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_offset;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        checksum_ok;
    logic        is_nav_pvt;
    logic        fix_valid;
  } res_t;

endpackage

// ----- hdl/ubxp_core.sv -----
module ubxp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                byte_take,
  input  logic [7:0]          rx_byte,
  output logic                res_load,
  output ubxp_pkg::res_t      res
);

  ubxp_pkg::phase_t phase, phase_next;
  logic [15:0] max_len;
  logic [7:0]  cur_class, cur_class_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [15:0] cur_length, cur_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  rcv_sum_a, rcv_sum_a_next;
  logic [7:0]  fix_type, fix_type_next;
  logic        fix_flag, fix_flag_next;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        pvt;

  // running fletcher sums with the current byte folded in
  assign add_a     = sum_a + rx_byte;
  assign add_b     = sum_b + add_a;
  assign len_full  = {rx_byte, cur_length[7:0]};
  assign count_inc = payload_count + 16'd1;
  assign pvt = (cur_class == ubxp_pkg::CLASS_NAV) && (cur_id == ubxp_pkg::ID_PVT) &&
               (cur_length >= ubxp_pkg::PVT_MIN_LEN);

  always_comb begin
    phase_next         = phase;
    cur_class_next     = cur_class;
    cur_id_next        = cur_id;
    cur_length_next    = cur_length;
    payload_count_next = payload_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    rcv_sum_a_next     = rcv_sum_a;
    fix_type_next      = fix_type;
    fix_flag_next      = fix_flag;
    res_load           = 1'b0;
    res                = '0;
    res.msg_class      = cur_class;
    res.msg_id         = cur_id;
    res.payload_length = cur_length;
    unique case (phase)
      ubxp_pkg::PH_HUNT1: begin
        if (rx_byte == ubxp_pkg::SYNC_FIRST) phase_next = ubxp_pkg::PH_HUNT2;
      end
      ubxp_pkg::PH_HUNT2: begin
        if (rx_byte == ubxp_pkg::SYNC_SECOND) begin
          sum_a_next         = '0;
          sum_b_next         = '0;
          payload_count_next = '0;
          fix_type_next      = '0;
          fix_flag_next      = 1'b0;
          phase_next         = ubxp_pkg::PH_CLASS;
        end else if (rx_byte != ubxp_pkg::SYNC_FIRST) begin
          phase_next = ubxp_pkg::PH_HUNT1;
        end
      end
      ubxp_pkg::PH_CLASS: begin
        cur_class_next = rx_byte;
        sum_a_next     = add_a;
        sum_b_next     = add_b;
        phase_next     = ubxp_pkg::PH_ID;
      end
      ubxp_pkg::PH_ID: begin
        cur_id_next = rx_byte;
        sum_a_next  = add_a;
        sum_b_next  = add_b;
        phase_next  = ubxp_pkg::PH_LENLO;
      end
      ubxp_pkg::PH_LENLO: begin
        cur_length_next = {8'd0, rx_byte};
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        phase_next      = ubxp_pkg::PH_LENHI;
      end
      ubxp_pkg::PH_LENHI: begin
        if (len_full > max_len) begin
          // over-long frame: drop and clear
          phase_next         = ubxp_pkg::PH_HUNT1;
          cur_class_next     = '0;
          cur_id_next        = '0;
          cur_length_next    = '0;
          payload_count_next = '0;
          sum_a_next         = '0;
          sum_b_next         = '0;
          rcv_sum_a_next     = '0;
          fix_type_next      = '0;
          fix_flag_next      = 1'b0;
        end else begin
          cur_length_next    = len_full;
          sum_a_next         = add_a;
          sum_b_next         = add_b;
          payload_count_next = '0;
          phase_next = (len_full == 16'd0) ? ubxp_pkg::PH_CKA : ubxp_pkg::PH_PAYLOAD;
        end
      end
      ubxp_pkg::PH_PAYLOAD: begin
        if (payload_count == ubxp_pkg::FIX_TYPE_OFS) fix_type_next = rx_byte;
        if (payload_count == ubxp_pkg::FIX_FLAG_OFS) fix_flag_next = rx_byte[0];
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        payload_count_next = count_inc;
        if (count_inc >= cur_length) phase_next = ubxp_pkg::PH_CKA;
        res_load           = 1'b1;
        res.result_kind    = ubxp_pkg::KIND_PAYLOAD;
        res.payload_offset = payload_count;
        res.payload_byte   = rx_byte;
      end
      ubxp_pkg::PH_CKA: begin
        rcv_sum_a_next = rx_byte;
        phase_next     = ubxp_pkg::PH_CKB;
      end
      ubxp_pkg::PH_CKB: begin
        res_load        = 1'b1;
        res.result_kind = ubxp_pkg::KIND_VERDICT;
        res.checksum_ok = (sum_a == rcv_sum_a) && (sum_b == rx_byte);
        res.is_nav_pvt  = pvt;
        res.fix_valid   = pvt && (fix_type >= ubxp_pkg::FIX_TYPE_MIN) && fix_flag;
        phase_next         = ubxp_pkg::PH_HUNT1;
        cur_class_next     = '0;
        cur_id_next        = '0;
        cur_length_next    = '0;
        payload_count_next = '0;
        sum_a_next         = '0;
        sum_b_next         = '0;
        rcv_sum_a_next     = '0;
        fix_type_next      = '0;
        fix_flag_next      = 1'b0;
      end
      default: begin
        phase_next = ubxp_pkg::PH_HUNT1;
      end
    endcase
    if (!byte_take) res_load = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len       <= ubxp_pkg::MAX_LEN_RST;
      phase         <= ubxp_pkg::PH_HUNT1;
      cur_class     <= '0;
      cur_id        <= '0;
      cur_length    <= '0;
      payload_count <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
      rcv_sum_a     <= '0;
      fix_type      <= '0;
      fix_flag      <= 1'b0;
    end else begin
      if (cfg_wr_en) max_len <= cfg_wr_data;
      if (byte_take) begin
        phase         <= phase_next;
        cur_class     <= cur_class_next;
        cur_id        <= cur_id_next;
        cur_length    <= cur_length_next;
        payload_count <= payload_count_next;
        sum_a         <= sum_a_next;
        sum_b         <= sum_b_next;
        rcv_sum_a     <= rcv_sum_a_next;
        fix_type      <= fix_type_next;
        fix_flag      <= fix_flag_next;
      end
    end
  end

endmodule

// ----- hdl/ubxp_out_reg.sv -----
module ubxp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ubxp_pkg::res_t     din,
  output logic               full_stall,
  output logic               res_valid,
  input  logic               res_stall,
  output ubxp_pkg::res_t     dout
);

  logic occupied;

  // upstream waits only while a held request is not taken
  assign full_stall = occupied && res_stall;
  assign res_valid  = occupied;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (!full_stall) begin
      occupied <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (!full_stall && load) dout <= din;
  end

endmodule

// ----- hdl/ubx_frame_parser.sv -----
// binary gnss frame deframer, one received byte per request
// a payload byte or frame-end verdict is registered and appears in the cycle after its byte is taken
// throughput: one byte per cycle while rx_stall is low, set by the parser state update
// rx_stall rises only while a held result request is stalled downstream
// reset (rst, synchronous): hunting for the first sync byte, frame state zero,
// max_payload_len back to 512, result register empty
module ubx_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_payload_len
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte input channel
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        result_kind,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_offset,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_length,
  output logic        checksum_ok,
  output logic        is_nav_pvt,
  output logic        fix_valid
);

  logic           byte_take;
  logic           res_load;
  ubxp_pkg::res_t res_comb;
  ubxp_pkg::res_t res_q;

  // a byte is taken whenever the result register can accept its outcome
  assign byte_take = rx_valid && !rx_stall;

  // parser state machine, fletcher sums and verdict logic
  ubxp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_take   (byte_take),
    .rx_byte     (rx_byte),
    .res_load    (res_load),
    .res         (res_comb)
  );

  // result register between the parser and the downstream side
  ubxp_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .din        (res_comb),
    .full_stall (rx_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .dout       (res_q)
  );

  // unpack the held result onto its ports
  assign result_kind    = res_q.result_kind;
  assign msg_class      = res_q.msg_class;
  assign msg_id         = res_q.msg_id;
  assign payload_offset = res_q.payload_offset;
  assign payload_byte   = res_q.payload_byte;
  assign payload_length = res_q.payload_length;
  assign checksum_ok    = res_q.checksum_ok;
  assign is_nav_pvt     = res_q.is_nav_pvt;
  assign fix_valid      = res_q.fix_valid;

endmodule

// ----- verif/tb_ubx_frame_parser.sv -----
`default_nettype none

module tb_ubx_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ubxp_pkg::*;

  // run limits
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int          MAX_REPORTED = 10;
  localparam int          SETTLE_CYCLES = 4;

  // clock, reset and block ports; all the ones driven here are known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_offset;
  logic [7:0]  payload_byte;
  logic [15:0] payload_length;
  logic        checksum_ok;
  logic        is_nav_pvt;
  logic        fix_valid;

  ubx_frame_parser uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .result_kind    (result_kind),
    .msg_class      (msg_class),
    .msg_id         (msg_id),
    .payload_offset (payload_offset),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .checksum_ok    (checksum_ok),
    .is_nav_pvt     (is_nav_pvt),
    .fix_valid      (fix_valid)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // idle rates for the two sides, in percent
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 46;

  // deframer shadow state, updated at each accepted request
  phase_t      frame_phase;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_len;
  logic [15:0] frame_count;
  logic [7:0]  fletch_a;
  logic [7:0]  fletch_b;
  logic [7:0]  rx_ck_a;
  logic [7:0]  fix_type_cap;
  logic        fix_flag_cap;
  logic [15:0] max_len_copy;

  // results still owed by the block, oldest first
  res_t expected_q[$];

  // bookkeeping
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned frames_sent   = 0;
  int unsigned bytes_checked = 0;
  int unsigned verdicts_seen = 0;
  int unsigned verdicts_ok   = 0;
  int unsigned pvt_seen      = 0;
  int unsigned fix_seen      = 0;
  int unsigned frames_dropped = 0;

  // drop everything about the frame in progress and go back to hunting
  function automatic void clear_frame();
    frame_phase  = PH_HUNT1;
    frame_class  = '0;
    frame_id     = '0;
    frame_len    = '0;
    frame_count  = '0;
    fletch_a     = '0;
    fletch_b     = '0;
    rx_ck_a      = '0;
    fix_type_cap = '0;
    fix_flag_cap = 1'b0;
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    fletch_a = fletch_a + b;
    fletch_b = fletch_b + fletch_a;
  endfunction

  // advance the deframer shadow by one byte and queue any result it owes
  function automatic void deframe_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.msg_class      = frame_class;
    r.msg_id         = frame_id;
    r.payload_length = frame_len;
    case (frame_phase)
      PH_HUNT1: begin
        if (b == SYNC_FIRST) frame_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == SYNC_SECOND) begin
          fletch_a     = '0;
          fletch_b     = '0;
          frame_count  = '0;
          fix_type_cap = '0;
          fix_flag_cap = 1'b0;
          frame_phase  = PH_CLASS;
        end else begin
          // a repeated first sync byte keeps waiting for the second one
          frame_phase = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end
      end
      PH_CLASS: begin
        frame_class = b;
        fletcher_add(b);
        frame_phase = PH_ID;
      end
      PH_ID: begin
        frame_id = b;
        fletcher_add(b);
        frame_phase = PH_LENLO;
      end
      PH_LENLO: begin
        frame_len = {8'h00, b};
        fletcher_add(b);
        frame_phase = PH_LENHI;
      end
      PH_LENHI: begin
        frame_len = {b, frame_len[7:0]};
        fletcher_add(b);
        if (frame_len > max_len_copy) begin
          // over-long frame vanishes without a result
          frames_dropped++;
          clear_frame();
        end else begin
          frame_count = '0;
          frame_phase = (frame_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (frame_count == FIX_TYPE_OFS) fix_type_cap = b;
        if (frame_count == FIX_FLAG_OFS) fix_flag_cap = b[0];
        fletcher_add(b);
        r.result_kind    = KIND_PAYLOAD;
        r.payload_offset = frame_count;
        r.payload_byte   = b;
        expected_q.push_back(r);
        frame_count = frame_count + 16'd1;
        if (frame_count >= frame_len) frame_phase = PH_CKA;
      end
      PH_CKA: begin
        rx_ck_a     = b;
        frame_phase = PH_CKB;
      end
      PH_CKB: begin
        r.result_kind = KIND_VERDICT;
        r.checksum_ok = (fletch_a == rx_ck_a) && (fletch_b == b);
        r.is_nav_pvt  = (frame_class == CLASS_NAV) && (frame_id == ID_PVT) &&
                        (frame_len >= PVT_MIN_LEN);
        r.fix_valid   = r.is_nav_pvt && (fix_type_cap >= FIX_TYPE_MIN) && fix_flag_cap;
        expected_q.push_back(r);
        clear_frame();
      end
      default: clear_frame();
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input res_t exp_r,
                                          input res_t got_r);
    mismatches++;
    if (mismatches <= MAX_REPORTED) begin
      $display("[%0t] %s", $realtime, what);
      $display("  exp kind=%0d cls=%h id=%h ofs=%0d byte=%h len=%0d ok=%0d pvt=%0d fix=%0d",
               exp_r.result_kind, exp_r.msg_class, exp_r.msg_id, exp_r.payload_offset,
               exp_r.payload_byte, exp_r.payload_length, exp_r.checksum_ok,
               exp_r.is_nav_pvt, exp_r.fix_valid);
      $display("  got kind=%0d cls=%h id=%h ofs=%0d byte=%h len=%0d ok=%0d pvt=%0d fix=%0d",
               got_r.result_kind, got_r.msg_class, got_r.msg_id, got_r.payload_offset,
               got_r.payload_byte, got_r.payload_length, got_r.checksum_ok,
               got_r.is_nav_pvt, got_r.fix_valid);
    end
  endfunction

  // compare one delivered result against the oldest one owed
  function automatic void check_result(input res_t got_r);
    res_t exp_r;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing expected", '0, got_r);
    end else begin
      exp_r = expected_q.pop_front();
      if (got_r.result_kind    !== exp_r.result_kind    ||
          got_r.msg_class      !== exp_r.msg_class      ||
          got_r.msg_id         !== exp_r.msg_id         ||
          got_r.payload_offset !== exp_r.payload_offset ||
          got_r.payload_byte   !== exp_r.payload_byte   ||
          got_r.payload_length !== exp_r.payload_length ||
          got_r.checksum_ok    !== exp_r.checksum_ok    ||
          got_r.is_nav_pvt     !== exp_r.is_nav_pvt     ||
          got_r.fix_valid      !== exp_r.fix_valid)
        report_mismatch("result field mismatch", exp_r, got_r);
      if (exp_r.result_kind == KIND_VERDICT) begin
        verdicts_seen++;
        if (exp_r.checksum_ok) verdicts_ok++;
        if (exp_r.is_nav_pvt) pvt_seen++;
        if (exp_r.fix_valid) fix_seen++;
      end else begin
        bytes_checked++;
      end
    end
  endfunction

  // sample both channels and the config port with pre-edge values
  always @(posedge clk) begin : monitor
    res_t got_r;
    if (rst) begin
      clear_frame();
      max_len_copy = MAX_LEN_RST;
    end else begin
      if (cfg_wr_en) max_len_copy = cfg_wr_data;
      if (res_valid && !res_stall) begin
        got_r = '{result_kind, msg_class, msg_id, payload_offset, payload_byte,
                  payload_length, checksum_ok, is_nav_pvt, fix_valid};
        check_result(got_r);
      end
      // result of a byte shows up in the cycle after it at the earliest
      if (rx_valid && !rx_stall) deframe_byte(rx_byte);
    end
  end

  // random downstream back-pressure
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // present one byte request, with random gaps ahead of it, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
  endtask

  // stop sending until every owed result has come, then let the block settle
  task automatic wait_drained();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // full frame with a correct or deliberately spoiled checksum
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input logic [7:0] ftype,
                            input logic [7:0] fflag, input bit corrupt);
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] b;
    logic [7:0] hdr [4];
    ck_a = '0;
    ck_b = '0;
    hdr  = '{cls, id, len[7:0], len[15:8]};
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (hdr[i]) begin
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
      send_byte(hdr[i]);
    end
    for (int i = 0; i < len; i++) begin
      if (i == FIX_TYPE_OFS) b = ftype;
      else if (i == FIX_FLAG_OFS) b = fflag;
      else b = 8'($urandom_range(255));
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
      send_byte(b);
    end
    if (corrupt) begin
      if ($urandom_range(1)) ck_a ^= 8'($urandom_range(1, 255));
      else ck_b ^= 8'($urandom_range(1, 255));
    end
    send_byte(ck_a);
    send_byte(ck_b);
    frames_sent++;
  endtask

  // sync plus header of a frame whose length is meant to be refused
  task automatic send_dropped_header(input logic [7:0] cls, input logic [7:0] id,
                                     input logic [15:0] len);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cls);
    send_byte(id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  // short hand-picked cases at reset limits
  task automatic test_directed_cases();
    // empty payload, good checksum
    send_frame(8'h0A, 8'h04, 16'd0, 8'h00, 8'h00, 1'b0);
    // extra first sync byte, then an empty frame with a bad checksum
    send_byte(SYNC_FIRST);
    send_frame(8'hFF, 8'hFF, 16'd0, 8'h00, 8'h00, 1'b1);
    // sync broken by a stray byte
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    // sender holds off until everything is out
    wait_drained();
    // largest declared length is refused at the reset limit
    send_dropped_header(CLASS_NAV, ID_PVT, 16'hFFFF);
  endtask

  // extremes of the length limit register
  task automatic test_length_limits();
    write_max_len(16'd0);
    send_frame(8'h05, 8'h01, 16'd0, 8'h00, 8'h00, 1'b0);
    send_dropped_header(8'h05, 8'h01, 16'd1);
    write_max_len(PVT_MIN_LEN);
    send_frame(CLASS_NAV, ID_PVT, PVT_MIN_LEN, 8'd3, 8'h01, 1'b0);
    send_dropped_header(CLASS_NAV, ID_PVT, PVT_MIN_LEN + 16'd1);
    write_max_len(16'hFFFF);
    // longer than the previous limit, now accepted
    send_frame(8'h02, 8'h15, 16'd100, 8'h00, 8'h00, 1'b0);
  endtask

  // mostly well-formed frames with random content, some noise and broken frames
  task automatic test_random_traffic(input int n_items, input int unsigned s_pct,
                                     input int unsigned r_pct, input logic [15:0] max_len);
    int          sent;
    int unsigned pick;
    int unsigned len;
    int unsigned room;
    logic [7:0]  cls;
    logic [7:0]  id;
    write_max_len(max_len);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        // line noise, biased toward sync bytes
        repeat ($urandom_range(1, 4))
          send_byte($urandom_range(2) == 0 ? SYNC_FIRST : 8'($urandom_range(255)));
      end else if (pick < 9) begin
        wait_drained();
      end else begin
        pick = $urandom_range(99);
        cls  = 8'($urandom_range(255));
        id   = 8'($urandom_range(255));
        if (pick < 50) begin
          len = $urandom_range(0, 12);
          if ($urandom_range(3) == 0) cls = CLASS_NAV;
        end else if (pick < 70) begin
          cls = CLASS_NAV;
          id  = ID_PVT;
          len = $urandom_range(PVT_MIN_LEN, PVT_MIN_LEN + 8);
        end else if (pick < 82) begin
          // position message too short to count
          cls = CLASS_NAV;
          id  = ID_PVT;
          len = $urandom_range(FIX_FLAG_OFS + 1, PVT_MIN_LEN - 1);
        end else begin
          len = $urandom_range(13, 40);
        end
        if (pick >= 94 && max_len != 16'hFFFF) begin
          room = 16'hFFFF - max_len;
          len  = max_len + $urandom_range(1, room < 300 ? room : 300);
          send_dropped_header(cls, id, 16'(len));
          sent += 6;
        end else begin
          send_frame(cls, id, 16'(len), 8'($urandom_range(0, 4)), 8'($urandom_range(255)),
                     $urandom_range(99) < 15);
          sent += len + 8;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_length_limits();
    test_random_traffic(150, 14, 46, MAX_LEN_RST);
    test_random_traffic(150, 46, 14, PVT_MIN_LEN + 16'd3);
    test_random_traffic(150, 0, 0, 16'hFFFF);

    // drain, then wait for the last results to come out of the result register
    rx_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_q.size());
    end

    $display("covered %0d frames (%0d dropped as over-long), %0d payload bytes checked",
             frames_sent, frames_dropped, bytes_checked);
    $display("verdicts: %0d total, %0d checksum good, %0d position, %0d with valid fix",
             verdicts_seen, verdicts_ok, pvt_seen, fix_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
